[rtl/stt_pkg.sv]
// Types and constants shared by the schema text tokenizer.
package stt_pkg;

    typedef enum logic [2:0] {
        MODE_IDLE  = 3'd0,
        MODE_SLASH = 3'd1,
        MODE_LINE  = 3'd2,
        MODE_BLOCK = 3'd3,
        MODE_STAR  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_NUMBER = 2'd1,
        KIND_WORD   = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        TT_BAD    = 3'd0,
        TT_LBRACE = 3'd1,
        TT_RBRACE = 3'd2,
        TT_EQUAL  = 3'd3,
        TT_SEMI   = 3'd4,
        TT_NUMBER = 3'd5,
        TT_WORD   = 3'd6,
        TT_END    = 3'd7
    } t_tok;

    localparam logic       EV_CHAR  = 1'b0;
    localparam logic       EV_TOKEN = 1'b1;

    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_EQUAL  = 8'h3D;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_VT     = 8'h0B;
    localparam logic [7:0] CH_FF     = 8'h0C;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;

    localparam logic [30:0] VALUE_MAX = 31'h7FFF_FFFF;

    typedef struct packed {
        logic [7:0] input_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic        event_type;
        t_tok        token_type;
        logic [7:0]  token_char;
        logic [6:0]  token_length;
        logic [30:0] number_value;
        logic [31:0] line_number;
        logic        too_long;
        logic        last_result;
    } t_out_item;

endpackage

[rtl/stt_if.sv]
// Valid/ready channels for tokenizer input bytes and result events.
interface stt_in_if;
    logic               valid;
    logic               ready;
    stt_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface stt_out_if;
    logic               valid;
    logic               ready;
    stt_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/schema_text_tokenizer_top.sv]
// Schema text tokenizer: byte stream in, character and token events out.
//
// i_in carries one byte per item, or an end-of-input mark. o_out carries
// result events: a character event for each byte added to a number or word,
// and a token event when a token completes. One input item yields zero, one
// or two events, the last one flagged by last_result.
// Each accepted item is decoded against the scan state in the same cycle and
// its events are written into a four-entry result queue; o_out shows the
// registered head of that queue.
// Input is taken every cycle while the queue has room for two events, so
// with no receiver stall an item that yields at most one event sustains one
// item per cycle; items that yield two events are limited by the output side
// to one event per cycle. When the receiver stalls, the queue fills and
// i_in.ready drops once fewer than two free entries remain; no event is lost or repeated.
// Synchronous active-low reset empties the queue, returns the scanner to
// idle with no pending token and clears the line count.
module schema_text_tokenizer_top #(
    parameter int MAX_TOKEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    stt_in_if.sink     i_in,
    stt_out_if.source  o_out
);
    import stt_pkg::*;

    localparam int LEN_W = $clog2(MAX_TOKEN + 1);
    localparam int DEPTH = 4;
    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_mode             r_mode, n_mode;
    t_kind             r_kind, n_kind;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [30:0]       r_value, n_value;
    logic [31:0]       r_line, n_line;

    t_out_item         r_q [DEPTH];
    t_out_item         n_q [DEPTH];
    logic [CNT_W-1:0]  r_count, n_count;

    t_out_item         res0, res1;
    logic [1:0]        res_n;
    logic              push, pop;

    logic [7:0]        c;
    logic              eoi, nl, is_digit, is_delim, is_ws, full;
    logic [34:0]       v_ext;
    logic [30:0]       v_next;
    logic [LEN_W-1:0]  len_inc;
    t_tok              delim_tt, flush_tt;

    function automatic t_out_item mk_token(t_tok tt, logic [6:0] len,
                                           logic [30:0] val, logic tl,
                                           logic [31:0] line);
        t_out_item r;
        r.event_type   = EV_TOKEN;
        r.token_type   = tt;
        r.token_char   = 8'd0;
        r.token_length = len;
        r.number_value = val;
        r.line_number  = line;
        r.too_long     = tl;
        r.last_result  = 1'b0;
        return r;
    endfunction

    assign push        = i_in.valid && i_in.ready;
    assign pop         = o_out.valid && o_out.ready;
    assign i_in.ready  = r_count <= CNT_W'(DEPTH - 2);
    assign o_out.valid = r_count != '0;
    assign o_out.data  = r_q[0];

    assign c        = i_in.data.input_byte;
    assign eoi      = i_in.data.end_of_input;
    assign nl       = (c == CH_LF) || (c == CH_CR);
    assign is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    assign is_delim = (c == CH_LBRACE) || (c == CH_RBRACE) ||
                      (c == CH_EQUAL) || (c == CH_SEMI);
    assign is_ws    = (c == CH_SPACE) || (c == CH_TAB) ||
                      (c == CH_VT) || (c == CH_FF);
    assign full     = r_len >= LEN_W'(MAX_TOKEN);
    assign len_inc  = r_len + 1'b1;
    assign flush_tt = (r_kind == KIND_NUMBER) ? TT_NUMBER : TT_WORD;
    assign delim_tt = (c == CH_LBRACE) ? TT_LBRACE :
                      (c == CH_RBRACE) ? TT_RBRACE :
                      (c == CH_EQUAL)  ? TT_EQUAL  : TT_SEMI;

    // value * 10 + digit, saturating
    assign v_ext  = ({4'd0, r_value} << 3) + ({4'd0, r_value} << 1) +
                    35'(c - CH_ZERO);
    assign v_next = (v_ext > 35'(VALUE_MAX)) ? VALUE_MAX : v_ext[30:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= MODE_IDLE;
            r_kind  <= KIND_NONE;
            r_len   <= '0;
            r_value <= '0;
            r_line  <= '0;
            r_count <= '0;
        end else begin
            r_mode  <= n_mode;
            r_kind  <= n_kind;
            r_len   <= n_len;
            r_value <= n_value;
            r_line  <= n_line;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

    // scanner: next state and events for the item on i_in
    always_comb begin
        t_out_item flush_res;
        flush_res = mk_token(flush_tt, 7'(r_len), r_value, 1'b0, r_line);
        n_mode  = r_mode;
        n_kind  = r_kind;
        n_len   = r_len;
        n_value = r_value;
        n_line  = r_line;
        res0    = mk_token(TT_END, 7'd0, 31'd0, 1'b0, r_line);
        res1    = res0;
        res_n   = 2'd0;
        if (eoi) begin
            n_mode  = MODE_IDLE;
            n_kind  = KIND_NONE;
            n_len   = '0;
            n_value = '0;
            if (r_mode == MODE_IDLE && r_kind != KIND_NONE) begin
                res0 = flush_res;
                res0.too_long = full;
                res_n = 2'd2;
            end else if (r_mode == MODE_SLASH) begin
                res0  = mk_token(TT_BAD, 7'd0, 31'd0, 1'b0, r_line);
                res_n = 2'd2;
            end else begin
                res_n = 2'd1;
            end
        end else begin
            unique case (r_mode)
                MODE_SLASH: begin
                    if (c == CH_SLASH) begin
                        n_mode = MODE_LINE;
                    end else if (c == CH_STAR) begin
                        n_mode = MODE_BLOCK;
                    end else begin
                        n_mode = MODE_IDLE;
                        res0   = mk_token(TT_BAD, 7'd0, 31'd0, 1'b0, r_line);
                        res_n  = 2'd1;
                    end
                end
                MODE_LINE: begin
                    if (nl) begin
                        n_line = r_line + 32'd1;
                        n_mode = MODE_IDLE;
                    end
                end
                MODE_BLOCK, MODE_STAR: begin
                    if (r_mode == MODE_STAR && c == CH_SLASH) begin
                        n_mode = MODE_IDLE;
                    end else begin
                        n_mode = (c == CH_STAR) ? MODE_STAR : MODE_BLOCK;
                        if (nl) begin
                            n_line = r_line + 32'd1;
                        end
                    end
                end
                default: begin
                    if (r_kind != KIND_NONE && full) begin
                        res0 = flush_res;
                        res0.too_long = 1'b1;
                        res_n   = 2'd1;
                        n_kind  = KIND_NONE;
                        n_len   = '0;
                        n_value = '0;
                    end else if (is_delim || c == CH_SLASH || nl || is_ws) begin
                        n_kind  = KIND_NONE;
                        n_len   = '0;
                        n_value = '0;
                        if (r_kind != KIND_NONE) begin
                            res0  = flush_res;
                            res_n = 2'd1;
                        end
                        if (is_delim) begin
                            if (r_kind != KIND_NONE) begin
                                res1  = mk_token(delim_tt, 7'd1, 31'd0, 1'b0, r_line);
                                res_n = 2'd2;
                            end else begin
                                res0  = mk_token(delim_tt, 7'd1, 31'd0, 1'b0, r_line);
                                res_n = 2'd1;
                            end
                        end
                        if (c == CH_SLASH) begin
                            n_mode = MODE_SLASH;
                        end
                        if (nl) begin
                            n_line = r_line + 32'd1;
                        end
                    end else begin
                        if (is_digit && r_kind != KIND_WORD) begin
                            n_kind  = KIND_NUMBER;
                            n_value = v_next;
                        end else if (!is_digit) begin
                            n_kind = KIND_WORD;
                        end
                        n_len = len_inc;
                        res0.event_type   = EV_CHAR;
                        res0.token_type   = (n_kind == KIND_NUMBER) ? TT_NUMBER : TT_WORD;
                        res0.token_char   = c;
                        res0.token_length = 7'(len_inc);
                        res0.number_value = n_value;
                        res_n = 2'd1;
                    end
                end
            endcase
        end
        res0.last_result = res_n == 2'd1;
        res1.last_result = 1'b1;
        if (!push) begin
            n_mode  = r_mode;
            n_kind  = r_kind;
            n_len   = r_len;
            n_value = r_value;
            n_line  = r_line;
        end
    end

    // result queue: pop from the head, append up to two events
    always_comb begin
        logic [CNT_W-1:0] cnt;
        logic [CNT_W-1:0] cnt1;
        for (int i = 0; i < DEPTH; i++) begin
            n_q[i] = r_q[i];
        end
        cnt = r_count;
        if (pop) begin
            for (int i = 0; i < DEPTH - 1; i++) begin
                n_q[i] = r_q[i + 1];
            end
            cnt = r_count - 1'b1;
        end
        cnt1 = cnt + 1'b1;
        if (push) begin
            if (res_n != 2'd0) begin
                n_q[cnt[IDX_W-1:0]] = res0;
            end
            if (res_n == 2'd2) begin
                n_q[cnt1[IDX_W-1:0]] = res1;
            end
            cnt = cnt + CNT_W'(res_n);
        end
        n_count = cnt;
    end

    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("result queue overflow");

    a_pending_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_kind != KIND_NONE) |-> (r_mode == MODE_IDLE))
        else $error("pending token outside idle scan");

    a_len_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= LEN_W'(MAX_TOKEN))
        else $error("pending length beyond limit");

    a_eoi_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && eoi) |=> (r_mode == MODE_IDLE && r_kind == KIND_NONE && r_len == '0))
        else $error("scanner not idle after end of input");

endmodule
